@@ sv/acc_pkg.sv @@
// Shared types, constants and helpers for the alarm clock controller.
package acc_pkg;

  // Field widths
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Counter ceiling and wrap points
  localparam logic [CNT_W-1:0]  CNT_MAX   = 10'd1023;
  localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;

  // Configuration reset values
  localparam logic [CNT_W-1:0] MODE_GUARD_RST = 10'd500;
  localparam logic [CNT_W-1:0] SET_GUARD_RST  = 10'd200;
  localparam logic [CNT_W-1:0] MS_PER_SEC_RST = 10'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE_GUARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_GUARD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MS_PER_SEC = 2'd2;

  // Operating modes
  typedef enum logic [2:0] {
    MODE_RUN          = 3'd0,
    MODE_SET_HOUR     = 3'd1,
    MODE_SET_MINUTE   = 3'd2,
    MODE_ALARM_HOUR   = 3'd3,
    MODE_ALARM_MINUTE = 3'd4
  } mode_t;

  // Accepted presses for one tick
  typedef struct packed {
    logic mode_hit;
    logic set_hit;
  } press_t;

  // State after one tick, as shown on the result word
  typedef struct packed {
    logic [HOUR_W-1:0] hour_now;
    logic [MIN_W-1:0]  minute_now;
    logic [MIN_W-1:0]  second_now;
    logic [HOUR_W-1:0] alarm_hour;
    logic [MIN_W-1:0]  alarm_minute;
    mode_t             mode;
    logic              alarm_enabled;
    logic              alarm_ringing;
    logic              buzzer_level;
    logic              blink_phase;
  } result_t;

  // Saturating millisecond counter step
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 10'd1;
  endfunction

endpackage

@@ sv/acc_press.sv @@
// Button guard timer: decides which button presses are accepted each tick.
module acc_press (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      mode_button,
  input  logic                      set_button,
  input  logic [acc_pkg::CNT_W-1:0] mode_guard_ms,
  input  logic [acc_pkg::CNT_W-1:0] set_guard_ms,
  output acc_pkg::press_t           presses
);
  import acc_pkg::*;

  logic [CNT_W-1:0] since_press_ms;
  logic [CNT_W-1:0] since_press_ms_next;
  logic [CNT_W-1:0] after_mode;
  logic [CNT_W-1:0] after_set;

  // Mode is checked first; an accepted mode press restarts the guard for set
  always_comb begin
    presses.mode_hit    = mode_button && (since_press_ms >= mode_guard_ms);
    after_mode          = presses.mode_hit ? '0 : since_press_ms;
    presses.set_hit     = set_button && (after_mode >= set_guard_ms);
    after_set           = presses.set_hit ? '0 : after_mode;
    since_press_ms_next = sat_inc(after_set);
  end

  // Advance the guard counter once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      since_press_ms <= '0;
    end else if (step) begin
      since_press_ms <= since_press_ms_next;
    end
  end

  a_press_restart: assert property (@(posedge clk) disable iff (rst)
    step && (presses.mode_hit || presses.set_hit) |=> since_press_ms == 10'd1)
    else $error("guard counter did not restart after an accepted press");

endmodule

@@ sv/acc_core.sv @@
// Time of day, alarm settings, mode and alarm logic, stepped once per tick.
module acc_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  acc_pkg::press_t           presses,
  input  logic [acc_pkg::CNT_W-1:0] ms_per_second,
  output acc_pkg::result_t          view
);
  import acc_pkg::*;

  logic [HOUR_W-1:0] hour_count, hour_count_next, hour_set;
  logic [MIN_W-1:0]  minute_count, minute_count_next, minute_set;
  logic [MIN_W-1:0]  second_count, second_count_next;
  logic [HOUR_W-1:0] alarm_hour, alarm_hour_next;
  logic [MIN_W-1:0]  alarm_minute, alarm_minute_next;
  mode_t             mode_state, mode_state_next;
  logic              alarm_enabled, alarm_enabled_next;
  logic              alarm_ringing, alarm_ringing_next, ringing_set;
  logic              alarm_blocked, alarm_blocked_next;
  logic [CNT_W-1:0]  since_second_ms, since_second_ms_next, sec_pos;
  logic              sec_tick;
  logic              phase;

  // Cycle the mode on an accepted mode press
  always_comb begin
    mode_state_next = mode_state;
    if (presses.mode_hit) begin
      case (mode_state)
        MODE_RUN:          mode_state_next = MODE_SET_HOUR;
        MODE_SET_HOUR:     mode_state_next = MODE_SET_MINUTE;
        MODE_SET_MINUTE:   mode_state_next = MODE_ALARM_HOUR;
        MODE_ALARM_HOUR:   mode_state_next = MODE_ALARM_MINUTE;
        default:           mode_state_next = MODE_RUN;
      endcase
    end
  end

  // Apply an accepted set press in the new mode
  always_comb begin
    hour_set           = hour_count;
    minute_set         = minute_count;
    alarm_hour_next    = alarm_hour;
    alarm_minute_next  = alarm_minute;
    alarm_enabled_next = alarm_enabled;
    ringing_set        = alarm_ringing;
    if (presses.set_hit) begin
      case (mode_state_next)
        MODE_RUN: begin
          if (alarm_ringing) begin
            ringing_set = 1'b0;
          end else begin
            alarm_enabled_next = !alarm_enabled;
          end
        end
        MODE_SET_HOUR:
          hour_set = (hour_count == HOUR_LAST) ? '0 : hour_count + 5'd1;
        MODE_SET_MINUTE:
          minute_set = (minute_count == MIN_LAST) ? '0 : minute_count + 6'd1;
        MODE_ALARM_HOUR:
          alarm_hour_next = (alarm_hour == HOUR_LAST) ? '0 : alarm_hour + 5'd1;
        MODE_ALARM_MINUTE:
          alarm_minute_next = (alarm_minute == MIN_LAST) ? '0 : alarm_minute + 6'd1;
        default: ;
      endcase
    end
  end

  // When a second is due, advance the clock one second, then compare against the alarm
  always_comb begin
    sec_tick           = since_second_ms >= ms_per_second;
    sec_pos            = since_second_ms;
    second_count_next  = second_count;
    minute_count_next  = minute_set;
    hour_count_next    = hour_set;
    alarm_blocked_next = alarm_blocked;
    alarm_ringing_next = ringing_set;
    if (sec_tick) begin
      sec_pos = '0;
      if (second_count == MIN_LAST) begin
        second_count_next  = '0;
        alarm_blocked_next = 1'b0;
        if (minute_set == MIN_LAST) begin
          minute_count_next = '0;
          hour_count_next   = (hour_set == HOUR_LAST) ? '0 : hour_set + 5'd1;
        end else begin
          minute_count_next = minute_set + 6'd1;
        end
      end else begin
        second_count_next = second_count + 6'd1;
      end
      if (alarm_hour_next == hour_count_next && alarm_minute_next == minute_count_next &&
          alarm_enabled_next && !alarm_blocked_next) begin
        alarm_ringing_next = 1'b1;
        alarm_blocked_next = 1'b1;
      end
    end
    since_second_ms_next = sat_inc(sec_pos);
    phase = {sec_pos, 1'b0} >= {1'b0, ms_per_second};
  end

  // Form the result word from the state after this tick
  always_comb begin
    view.hour_now      = hour_count_next;
    view.minute_now    = minute_count_next;
    view.second_now    = second_count_next;
    view.alarm_hour    = alarm_hour_next;
    view.alarm_minute  = alarm_minute_next;
    view.mode          = mode_state_next;
    view.alarm_enabled = alarm_enabled_next;
    view.alarm_ringing = alarm_ringing_next;
    view.buzzer_level  = alarm_ringing_next ? phase : 1'b1;
    view.blink_phase   = phase;
  end

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count      <= '0;
      minute_count    <= '0;
      second_count    <= '0;
      alarm_hour      <= '0;
      alarm_minute    <= '0;
      mode_state      <= MODE_RUN;
      alarm_enabled   <= 1'b1;
      alarm_ringing   <= 1'b0;
      alarm_blocked   <= 1'b0;
      since_second_ms <= '0;
    end else if (step) begin
      hour_count      <= hour_count_next;
      minute_count    <= minute_count_next;
      second_count    <= second_count_next;
      alarm_hour      <= alarm_hour_next;
      alarm_minute    <= alarm_minute_next;
      mode_state      <= mode_state_next;
      alarm_enabled   <= alarm_enabled_next;
      alarm_ringing   <= alarm_ringing_next;
      alarm_blocked   <= alarm_blocked_next;
      since_second_ms <= since_second_ms_next;
    end
  end

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    hour_count <= HOUR_LAST && minute_count <= MIN_LAST && second_count <= MIN_LAST &&
    alarm_hour <= HOUR_LAST && alarm_minute <= MIN_LAST)
    else $error("time or alarm field out of range");

  a_ring_blocks: assert property (@(posedge clk) disable iff (rst)
    step && !alarm_ringing && alarm_ringing_next |=> alarm_blocked)
    else $error("alarm started without blocking the minute");

endmodule

@@ sv/alarm_clock_controller.sv @@
// Top level of the alarm clock controller: configuration, tick handshake, result register.
// A 24-hour clock with one alarm. Each input word is one millisecond tick carrying the
// mode and set button levels; each tick yields one result word with the state after the
// tick. One tick is taken per clock cycle: the whole update is one pass of logic between
// the state registers and the result register, and a new tick is taken whenever the
// result register is empty or being drained in the same cycle. Configuration registers
// (guard times, ticks per second) reset to 500, 200 and 1000 and should be written only
// while no result is pending; writes to index 3 are ignored.
module alarm_clock_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [acc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acc_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode_button,
  input  logic                          set_button,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [acc_pkg::HOUR_W-1:0]    hour_now,
  output logic [acc_pkg::MIN_W-1:0]     minute_now,
  output logic [acc_pkg::MIN_W-1:0]     second_now,
  output logic [acc_pkg::HOUR_W-1:0]    alarm_hour_out,
  output logic [acc_pkg::MIN_W-1:0]     alarm_minute_out,
  output logic [2:0]                    mode_out,
  output logic                          alarm_enabled_out,
  output logic                          alarm_ringing_out,
  output logic                          buzzer_level,
  output logic                          blink_phase
);
  import acc_pkg::*;

  logic [CNT_W-1:0] mode_guard_ms;
  logic [CNT_W-1:0] set_guard_ms;
  logic [CNT_W-1:0] ms_per_second;
  logic             step;
  press_t           presses;
  result_t          view;

  // Take a tick when the result register can hold its word
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_guard_ms <= MODE_GUARD_RST;
      set_guard_ms  <= SET_GUARD_RST;
      ms_per_second <= MS_PER_SEC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE_GUARD: mode_guard_ms <= cfg_data;
        REG_SET_GUARD:  set_guard_ms  <= cfg_data;
        REG_MS_PER_SEC: ms_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  acc_press u_press (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .mode_button   (mode_button),
    .set_button    (set_button),
    .mode_guard_ms (mode_guard_ms),
    .set_guard_ms  (set_guard_ms),
    .presses       (presses)
  );

  acc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .presses       (presses),
    .ms_per_second (ms_per_second),
    .view          (view)
  );

  // Track whether the result register holds an undelivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result word on each accepted tick
  always_ff @(posedge clk) begin
    if (step) begin
      hour_now          <= view.hour_now;
      minute_now        <= view.minute_now;
      second_now        <= view.second_now;
      alarm_hour_out    <= view.alarm_hour;
      alarm_minute_out  <= view.alarm_minute;
      mode_out          <= view.mode;
      alarm_enabled_out <= view.alarm_enabled;
      alarm_ringing_out <= view.alarm_ringing;
      buzzer_level      <= view.buzzer_level;
      blink_phase       <= view.blink_phase;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("tick refused while the result register is empty");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted tick produced no result word");

  a_buzz_needs_ring: assert property (@(posedge clk) disable iff (rst)
    out_valid && !buzzer_level |-> alarm_ringing_out)
    else $error("buzzer sounding while the alarm is not ringing");

endmodule

@@ sim/tb_top.sv @@
// Testbench for the alarm clock controller: tick stimulus, clock predictor and word checks.
`timescale 1ns / 100ps

module tb_top;
  import acc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 200;
  localparam int DRAIN_CYCLES   = 4;

  // Predicts one result word per accepted tick and checks the words that come back
  class clock_scoreboard;
    logic [CNT_W-1:0]  mode_guard, set_guard, ms_per_sec;
    logic [HOUR_W-1:0] hour, alarm_hour;
    logic [MIN_W-1:0]  minute, second, alarm_minute;
    mode_t             mode;
    logic              enabled, ringing, blocked;
    logic [CNT_W-1:0]  since_press, since_second;
    result_t           expected_words[$];
    int                errors;

    function new();
      mode_guard   = MODE_GUARD_RST;
      set_guard    = SET_GUARD_RST;
      ms_per_sec   = MS_PER_SEC_RST;
      hour         = '0;
      minute       = '0;
      second       = '0;
      alarm_hour   = '0;
      alarm_minute = '0;
      mode         = MODE_RUN;
      enabled      = 1'b1;
      ringing      = 1'b0;
      blocked      = 1'b0;
      since_press  = '0;
      since_second = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
      case (idx)
        REG_MODE_GUARD: mode_guard = val;
        REG_SET_GUARD:  set_guard  = val;
        REG_MS_PER_SEC: ms_per_sec = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Advance the clock state by one tick and queue the word it should produce
    function void note_tick(logic mode_btn, logic set_btn);
      logic [CNT_W-1:0] d;
      logic [CNT_W:0]   twice;
      logic             phase;
      result_t          r;
      d = since_press;

      // mode press first, then set press against the same counter
      if (mode_btn && d >= mode_guard) begin
        d = '0;
        case (mode)
          MODE_RUN:        mode = MODE_SET_HOUR;
          MODE_SET_HOUR:   mode = MODE_SET_MINUTE;
          MODE_SET_MINUTE: mode = MODE_ALARM_HOUR;
          MODE_ALARM_HOUR: mode = MODE_ALARM_MINUTE;
          default:         mode = MODE_RUN;
        endcase
      end
      if (set_btn && d >= set_guard) begin
        d = '0;
        case (mode)
          MODE_RUN: begin
            if (ringing) ringing = 1'b0;
            else enabled = !enabled;
          end
          MODE_SET_HOUR:     hour = (hour == HOUR_LAST) ? '0 : hour + 5'd1;
          MODE_SET_MINUTE:   minute = (minute == MIN_LAST) ? '0 : minute + 6'd1;
          MODE_ALARM_HOUR:   alarm_hour = (alarm_hour == HOUR_LAST) ? '0 : alarm_hour + 5'd1;
          MODE_ALARM_MINUTE: begin
            alarm_minute = (alarm_minute == MIN_LAST) ? '0 : alarm_minute + 6'd1;
          end
          default: ;
        endcase
      end

      // one clock second, then the alarm compare
      if (since_second >= ms_per_sec) begin
        since_second = '0;
        if (second == MIN_LAST) begin
          second  = '0;
          blocked = 1'b0;
          if (minute == MIN_LAST) begin
            minute = '0;
            hour   = (hour == HOUR_LAST) ? '0 : hour + 5'd1;
          end else begin
            minute = minute + 6'd1;
          end
        end else begin
          second = second + 6'd1;
        end
        if (alarm_hour == hour && alarm_minute == minute && enabled && !blocked) begin
          ringing = 1'b1;
          blocked = 1'b1;
        end
      end

      twice = {since_second, 1'b0};
      phase = twice >= {1'b0, ms_per_sec};

      r.hour_now      = hour;
      r.minute_now    = minute;
      r.second_now    = second;
      r.alarm_hour    = alarm_hour;
      r.alarm_minute  = alarm_minute;
      r.mode          = mode;
      r.alarm_enabled = enabled;
      r.alarm_ringing = ringing;
      r.buzzer_level  = ringing ? phase : 1'b1;
      r.blink_phase   = phase;
      expected_words.push_back(r);

      // both counters saturate at the top
      since_press  = (d == CNT_MAX) ? d : d + 10'd1;
      since_second = (since_second == CNT_MAX) ? since_second : since_second + 10'd1;
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
        return;
      end
      want = expected_words.pop_front();
      cmp("hour_now", want.hour_now, got.hour_now);
      cmp("minute_now", want.minute_now, got.minute_now);
      cmp("second_now", want.second_now, got.second_now);
      cmp("alarm_hour_out", want.alarm_hour, got.alarm_hour);
      cmp("alarm_minute_out", want.alarm_minute, got.alarm_minute);
      cmp("mode_out", want.mode, got.mode);
      cmp("alarm_enabled_out", want.alarm_enabled, got.alarm_enabled);
      cmp("alarm_ringing_out", want.alarm_ringing, got.alarm_ringing);
      cmp("buzzer_level", want.buzzer_level, got.buzzer_level);
      cmp("blink_phase", want.blink_phase, got.blink_phase);
    endfunction
  endclass

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CNT_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 mode_button = 1'b0;
  logic                 set_button  = 1'b0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [HOUR_W-1:0]    hour_now;
  logic [MIN_W-1:0]     minute_now;
  logic [MIN_W-1:0]     second_now;
  logic [HOUR_W-1:0]    alarm_hour_out;
  logic [MIN_W-1:0]     alarm_minute_out;
  logic [2:0]           mode_out;
  logic                 alarm_enabled_out;
  logic                 alarm_ringing_out;
  logic                 buzzer_level;
  logic                 blink_phase;

  clock_scoreboard sb;
  bit calm = 1'b0;
  int ticks_sent = 0;

  alarm_clock_controller DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one tick word and hold it until accepted
  task automatic send_tick(input logic m, input logic s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode_button <= m;
    set_button  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(m, s);
    ticks_sent++;
  endtask

  // Wait out the guard, then press one button for a single tick
  task automatic press(input bit on_mode);
    logic [CNT_W-1:0] g;
    g = on_mode ? sb.mode_guard : sb.set_guard;
    while (sb.since_press < g) send_tick(1'b0, 1'b0);
    send_tick(on_mode, !on_mode);
  endtask

  task automatic go_mode(input mode_t target);
    while (sb.mode != target) press(1'b1);
  endtask

  task automatic set_time(input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m);
    int n;
    go_mode(MODE_SET_HOUR);
    n = 0;
    while (sb.hour != h && n < 60) begin
      press(1'b0);
      n++;
    end
    go_mode(MODE_SET_MINUTE);
    n = 0;
    while (sb.minute != m && n < 150) begin
      press(1'b0);
      n++;
    end
  endtask

  // Let the clock run with an occasional set press (silence or toggle)
  task automatic wait_run(input int n);
    repeat (n) send_tick(1'b0, $urandom_range(0, 39) == 0);
  endtask

  task automatic noise(input int n);
    repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Bring the time just ahead of the alarm (or to the end of the day) and let it ring
  task automatic ring_sequence();
    logic [MIN_W-1:0] m;
    if ($urandom_range(0, 2) == 0) begin
      go_mode(MODE_ALARM_HOUR);
      repeat ($urandom_range(0, 23)) press(1'b0);
      go_mode(MODE_ALARM_MINUTE);
      repeat ($urandom_range(0, 59)) press(1'b0);
    end
    if ($urandom_range(0, 3) == 0) begin
      set_time(HOUR_LAST, MIN_LAST);
    end else begin
      m = (sb.alarm_minute == '0) ? MIN_LAST : sb.alarm_minute - 6'd1;
      set_time(sb.alarm_hour, m);
    end
    go_mode(MODE_RUN);
    while (!sb.enabled) press(1'b0);
    wait_run(60 * (sb.ms_per_sec + 1) + $urandom_range(0, 60));
  endtask

  task automatic run_planned(input int n);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < n) begin
      if ($urandom_range(0, 3) != 0) ring_sequence();
      else noise($urandom_range(5, 40));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CNT_W-1:0] mg, sg, mps);
    write_reg(REG_MODE_GUARD, mg);
    write_reg(REG_SET_GUARD, sg);
    write_reg(REG_MS_PER_SEC, mps);
    write_reg(REG_SPARE, CNT_W'($urandom_range(0, 1023)));
    cfg_we <= 1'b0;
  endtask

  // Drop valid and wait until every expected word is back
  task automatic drain_ticks();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: check each word, stall at random, and hold off long at times
  initial begin
    result_t got;
    int hold;
    int words;
    hold  = 0;
    words = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.hour_now      = hour_now;
        got.minute_now    = minute_now;
        got.second_now    = second_now;
        got.alarm_hour    = alarm_hour_out;
        got.alarm_minute  = alarm_minute_out;
        got.mode          = mode_t'(mode_out);
        got.alarm_enabled = alarm_enabled_out;
        got.alarm_ringing = alarm_ringing_out;
        got.buzzer_level  = buzzer_level;
        got.blink_phase   = blink_phase;
        sb.check_word(got);
        words++;
        hold = (words == 60 || $urandom_range(0, 499) == 0) ? LONG_HOLD : pick_gap();
      end
      out_ready <= !rst && hold == 0;
      if (hold > 0) hold--;
    end
  end

  // End the run when neither side moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: no guards, a second on every tick, every mode and set action
    load_config('0, '0, '0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    repeat (4) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    drain_ticks();

    // Alarm and rollover sequences with short guards
    load_config(10'd1, '0, '0);
    run_planned(120);
    drain_ticks();

    calm = 1'b1;
    load_config(10'd2, 10'd1, 10'd2);
    run_planned(60);
    drain_ticks();
    calm = 1'b0;

    // Largest guards and the longest second
    load_config(CNT_MAX, CNT_MAX, CNT_MAX);
    noise(1100);
    drain_ticks();

    load_config(MODE_GUARD_RST, SET_GUARD_RST, MS_PER_SEC_RST);
    noise(100);
    drain_ticks();

    load_config(10'd7, 10'd3, 10'd1);
    run_planned(60);
    drain_ticks();

    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ alarm_clock_controller.f @@
sv/acc_pkg.sv
sv/acc_press.sv
sv/acc_core.sv
sv/alarm_clock_controller.sv
sim/tb_top.sv
